/* rtl/core/assert_macros.svh */
// assertion macros used by the assertion checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("page frame allocator assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("page frame allocator assertion failed");

`endif

/* rtl/core/pfa_pkg.sv */
// shared types, codes and controller/datapath structs of the page frame allocator
package pfa_pkg;

  localparam int FRAME_BITS = 36;
  localparam int OP_W       = 2;
  localparam int IDX_W      = 4;
  localparam int STATUS_W   = 2;
  localparam int RCOUNT_W   = 5;
  localparam int CFG_IDX_W  = 4;

  typedef logic [FRAME_BITS-1:0] frame_t;

  localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OP_W-1:0] OP_ALLOC = 2'd1;
  localparam logic [OP_W-1:0] OP_FREE  = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NOFIT = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_RANGE_COUNT = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BOOT_START  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BOOT_END    = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ARCH_READY  = 4'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_LD_SUB,
    S_LD_ADD,
    S_POP,
    S_PROBE,
    S_SCAN_RD,
    S_RESP
  } pfa_state_t;

  typedef struct packed {
    logic in_ready;
    logic rng_rd_item;
    logic rng_rd_cached;
    logic rng_rd_probe;
    logic stk_pop_rd;
    logic stk_push;
    logic ld_sub;
    logic ld_add;
    logic take;
    logic pop_done;
    logic scan_first;
    logic scan_next;
    logic res_zero;
    logic res_fail;
    logic res_full;
    logic out_load;
  } pfa_cmd_t;

  typedef struct packed {
    logic            req_valid;
    logic [OP_W-1:0] op;
    logic            idx_ok;
    logic            stk_empty;
    logic            stk_full;
    logic            fits;
    logic            scanning;
    logic            scan_empty;
    logic            scan_last;
    logic            out_free;
  } pfa_stat_t;

endpackage

/* rtl/core/pfa_if.sv */
// request, response and configuration channel interfaces
interface pfa_req_if;
  import pfa_pkg::*;
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     op;
  logic [IDX_W-1:0]    range_index;
  frame_t              range_start;
  frame_t              range_frames;
  frame_t              frame_addr;

  modport source (output valid, op, range_index, range_start, range_frames, frame_addr,
                  input ready);
  modport sink (input valid, op, range_index, range_start, range_frames, frame_addr,
                output ready);
endinterface

interface pfa_rsp_if;
  import pfa_pkg::*;
  logic                valid;
  logic                ready;
  frame_t              frame;
  logic [STATUS_W-1:0] status;
  frame_t              free_count;

  modport source (output valid, frame, status, free_count, input ready);
  modport sink (input valid, frame, status, free_count, output ready);
endinterface

interface pfa_cfg_if;
  import pfa_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  frame_t               data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* rtl/core/pfa_ram.sv */
// generic single-write, single-read ram with registered read data
module pfa_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/core/pfa_ctrl.sv */
// controller state machine of the page frame allocator
module pfa_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  pfa_pkg::pfa_stat_t stat,
  output pfa_pkg::pfa_cmd_t  cmd
);
  import pfa_pkg::*;

  pfa_state_t state;
  pfa_state_t state_next;
  logic       probe_fail;

  // nothing left to scan: a zero scan limit, or the probed entry is the last one within it
  assign probe_fail = stat.scanning ? stat.scan_last : stat.scan_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (stat.req_valid) state_next = S_DISPATCH;
      end
      S_DISPATCH: begin
        unique case (stat.op)
          OP_LOAD:  state_next = stat.idx_ok ? S_LD_SUB : S_RESP;
          OP_ALLOC: state_next = stat.stk_empty ? S_PROBE : S_POP;
          default:  state_next = S_RESP;
        endcase
      end
      S_LD_SUB:  state_next = S_LD_ADD;
      S_LD_ADD:  state_next = S_RESP;
      S_POP:     state_next = S_RESP;
      S_PROBE: begin
        if (stat.fits || probe_fail) begin
          state_next = S_RESP;
        end else begin
          state_next = S_SCAN_RD;
        end
      end
      S_SCAN_RD: state_next = S_PROBE;
      S_RESP: begin
        if (stat.out_free) state_next = S_IDLE;
      end
      default:   state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state)
      S_IDLE: cmd.in_ready = 1'b1;
      S_DISPATCH: begin
        unique case (stat.op)
          OP_LOAD: begin
            if (stat.idx_ok) begin
              cmd.rng_rd_item = 1'b1;
            end else begin
              cmd.res_zero = 1'b1;
            end
          end
          OP_ALLOC: begin
            if (stat.stk_empty) begin
              cmd.rng_rd_cached = 1'b1;
            end else begin
              cmd.stk_pop_rd = 1'b1;
            end
          end
          OP_FREE: begin
            if (stat.stk_full) begin
              cmd.res_full = 1'b1;
            end else begin
              cmd.stk_push = 1'b1;
            end
          end
          default: cmd.res_zero = 1'b1;
        endcase
      end
      S_LD_SUB: cmd.ld_sub = 1'b1;
      S_LD_ADD: cmd.ld_add = 1'b1;
      S_POP:    cmd.pop_done = 1'b1;
      S_PROBE: begin
        if (stat.fits) begin
          cmd.take = 1'b1;
        end else if (probe_fail) begin
          cmd.res_fail = 1'b1;
        end else if (stat.scanning) begin
          cmd.scan_next = 1'b1;
        end else begin
          cmd.scan_first = 1'b1;
        end
      end
      S_SCAN_RD: cmd.rng_rd_probe = 1'b1;
      S_RESP:    cmd.out_load = stat.out_free;
      default:   cmd = '0;
    endcase
  end

endmodule

/* rtl/core/pfa_dp.sv */
// datapath: config registers, range table, recycle stack, free count, output register
module pfa_dp #(
  parameter int NUM_RANGES  = 16,
  parameter int STACK_DEPTH = 1024
) (
  input  logic               clk,
  input  logic               rst,
  pfa_req_if.sink            req,
  pfa_rsp_if.source          rsp,
  pfa_cfg_if.sink            cfg,
  input  pfa_pkg::pfa_cmd_t  cmd,
  output pfa_pkg::pfa_stat_t stat
);
  import pfa_pkg::*;

  localparam int AW  = (NUM_RANGES > 1) ? $clog2(NUM_RANGES) : 1;
  localparam int CW  = ((AW > RCOUNT_W) ? AW : RCOUNT_W) + 2;
  localparam int SAW = $clog2(STACK_DEPTH);
  localparam int DW  = $clog2(STACK_DEPTH + 1);
  localparam int RW  = 2 * FRAME_BITS;
  localparam frame_t FRAME_MAX = '1;

  // configuration registers
  logic [RCOUNT_W-1:0] range_count;
  frame_t              boot_start;
  frame_t              boot_end;
  logic                arch_ready;

  assign cfg.ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      range_count <= '0;
      boot_start  <= '0;
      boot_end    <= '1;
      arch_ready  <= 1'b0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_RANGE_COUNT: range_count <= cfg.data[RCOUNT_W-1:0];
        REG_BOOT_START:  boot_start  <= cfg.data;
        REG_BOOT_END:    boot_end    <= cfg.data;
        REG_ARCH_READY:  arch_ready  <= cfg.data[0];
        default:         range_count <= range_count;
      endcase
    end
  end

  // request capture
  logic [OP_W-1:0]  op_q;
  logic [IDX_W-1:0] idx_q;
  frame_t           start_q;
  frame_t           frames_q;
  frame_t           addr_q;

  assign req.ready = cmd.in_ready && !rst;

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      op_q     <= req.op;
      idx_q    <= req.range_index;
      start_q  <= req.range_start;
      frames_q <= req.range_frames;
      addr_q   <= req.frame_addr;
    end
  end

  logic [CW-1:0] idx_ext;
  logic [AW-1:0] idx_addr;
  logic          idx_ok;

  assign idx_ext  = CW'(idx_q);
  assign idx_ok   = idx_ext < CW'(NUM_RANGES);
  assign idx_addr = idx_ext[AW-1:0];

  // range table: first frame and length packed in one ram word
  logic          rng_wr_en;
  logic [AW-1:0] rng_wr_addr;
  logic [RW-1:0] rng_wr_data;
  logic          rng_rd_en;
  logic [AW-1:0] rng_rd_addr;
  logic [RW-1:0] rng_rd_data;
  logic [NUM_RANGES-1:0] rng_valid;
  logic          rd_valid_q;
  frame_t        cur_first;
  frame_t        cur_len;

  logic [AW-1:0] probe_addr;
  logic [AW-1:0] cached_range;
  logic          scanning;
  logic [CW-1:0] scan_n;
  logic [CW-1:0] probe_next;
  logic          in_window;
  logic          fits;

  always_comb begin
    rng_rd_en = cmd.rng_rd_item | cmd.rng_rd_cached | cmd.rng_rd_probe;
    if (cmd.rng_rd_item) begin
      rng_rd_addr = idx_addr;
    end else if (cmd.rng_rd_cached) begin
      rng_rd_addr = cached_range;
    end else begin
      rng_rd_addr = probe_addr;
    end
  end

  // entries never loaded read as zero
  assign cur_first = rd_valid_q ? rng_rd_data[RW-1:FRAME_BITS] : '0;
  assign cur_len   = rd_valid_q ? rng_rd_data[FRAME_BITS-1:0] : '0;

  assign in_window = (cur_first >= boot_start) &&
                     (({1'b0, cur_first} + (FRAME_BITS+1)'(1)) < {1'b0, boot_end});
  assign fits      = (cur_len != '0) && (arch_ready || in_window);

  assign rng_wr_en   = cmd.ld_sub | cmd.take;
  assign rng_wr_addr = cmd.ld_sub ? idx_addr : probe_addr;
  assign rng_wr_data = cmd.ld_sub ? {start_q, frames_q}
                                  : {cur_first + frame_t'(1), cur_len - frame_t'(1)};

  pfa_ram #(
    .WIDTH (RW),
    .DEPTH (NUM_RANGES)
  ) u_range_ram (
    .clk     (clk),
    .wr_en   (rng_wr_en),
    .wr_addr (rng_wr_addr),
    .wr_data (rng_wr_data),
    .rd_en   (rng_rd_en),
    .rd_addr (rng_rd_addr),
    .rd_data (rng_rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rng_valid <= '0;
    end else if (rng_wr_en) begin
      rng_valid[rng_wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rng_rd_en) begin
      rd_valid_q <= rng_valid[rng_rd_addr];
    end
  end

  // scan limit clamps to the table size
  assign scan_n     = (CW'(range_count) > CW'(NUM_RANGES)) ? CW'(NUM_RANGES)
                                                           : CW'(range_count);
  assign probe_next = CW'(probe_addr) + CW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      probe_addr   <= '0;
      cached_range <= '0;
      scanning     <= 1'b0;
    end else begin
      if (cmd.rng_rd_cached) begin
        probe_addr <= cached_range;
        scanning   <= 1'b0;
      end
      if (cmd.scan_first) begin
        probe_addr <= '0;
        scanning   <= 1'b1;
      end
      if (cmd.scan_next) begin
        probe_addr <= probe_next[AW-1:0];
      end
      if (cmd.take) begin
        cached_range <= probe_addr;
      end
    end
  end

  // recycle stack
  logic [DW-1:0]  depth;
  logic [DW-1:0]  pop_idx;
  frame_t         stk_rd_data;
  logic           stk_empty;
  logic           stk_full;

  assign pop_idx   = depth - DW'(1);
  assign stk_empty = depth == '0;
  assign stk_full  = depth == DW'(STACK_DEPTH);

  pfa_ram #(
    .WIDTH (FRAME_BITS),
    .DEPTH (STACK_DEPTH)
  ) u_stack_ram (
    .clk     (clk),
    .wr_en   (cmd.stk_push),
    .wr_addr (depth[SAW-1:0]),
    .wr_data (addr_q),
    .rd_en   (cmd.stk_pop_rd),
    .rd_addr (pop_idx[SAW-1:0]),
    .rd_data (stk_rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      depth <= '0;
    end else if (cmd.stk_push) begin
      depth <= depth + DW'(1);
    end else if (cmd.stk_pop_rd) begin
      depth <= pop_idx;
    end
  end

  // free frame count, saturating both ways
  frame_t                avail_frames;
  frame_t                free_sub;
  frame_t                free_dec;
  frame_t                free_inc;
  logic [FRAME_BITS:0]   ld_sum;

  assign free_sub = (avail_frames > cur_len) ? (avail_frames - cur_len) : '0;
  assign ld_sum   = {1'b0, avail_frames} + {1'b0, frames_q};
  assign free_dec = (avail_frames != '0) ? (avail_frames - frame_t'(1)) : '0;
  assign free_inc = (avail_frames == FRAME_MAX) ? FRAME_MAX
                                                : (avail_frames + frame_t'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      avail_frames <= '0;
    end else if (cmd.ld_sub) begin
      avail_frames <= free_sub;
    end else if (cmd.ld_add) begin
      avail_frames <= ld_sum[FRAME_BITS] ? FRAME_MAX : ld_sum[FRAME_BITS-1:0];
    end else if (cmd.take || cmd.pop_done) begin
      avail_frames <= free_dec;
    end else if (cmd.stk_push) begin
      avail_frames <= free_inc;
    end
  end

  // result of the current request
  frame_t              res_frame;
  logic [STATUS_W-1:0] res_status;

  always_ff @(posedge clk) begin
    if (cmd.ld_add || cmd.stk_push || cmd.res_zero) begin
      res_frame  <= '0;
      res_status <= STATUS_OK;
    end else if (cmd.take) begin
      res_frame  <= cur_first;
      res_status <= STATUS_OK;
    end else if (cmd.pop_done) begin
      res_frame  <= stk_rd_data;
      res_status <= STATUS_OK;
    end else if (cmd.res_fail) begin
      res_frame  <= '0;
      res_status <= STATUS_NOFIT;
    end else if (cmd.res_full) begin
      res_frame  <= '0;
      res_status <= STATUS_FULL;
    end
  end

  // output register
  logic                out_valid;
  frame_t              out_frame;
  logic [STATUS_W-1:0] out_status;
  frame_t              out_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_frame  <= res_frame;
      out_status <= res_status;
      out_count  <= avail_frames;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.frame      = out_frame;
  assign rsp.status     = out_status;
  assign rsp.free_count = out_count;

  always_comb begin
    stat.req_valid  = req.valid;
    stat.op         = op_q;
    stat.idx_ok     = idx_ok;
    stat.stk_empty  = stk_empty;
    stat.stk_full   = stk_full;
    stat.fits       = fits;
    stat.scanning   = scanning;
    stat.scan_empty = scan_n == '0;
    stat.scan_last  = probe_next >= scan_n;
    stat.out_free   = !out_valid || rsp.ready;
  end

endmodule

/* rtl/core/page_frame_allocator.sv */
// page frame allocator top level: controller plus datapath
// an allocation after a scan does one range ram read per table entry probed
// one request at a time: the next is taken once the response is registered and the
//   controller is back in idle
// reset: synchronous; range table reads as empty through per-entry valid bits,
//   stack contents are left as they are and only entries below the stack depth are read
module page_frame_allocator #(
  parameter int NUM_RANGES  = 16,
  parameter int STACK_DEPTH = 1024
) (
  input logic       clk,
  input logic       rst,
  pfa_req_if.sink   req,
  pfa_rsp_if.source rsp,
  pfa_cfg_if.sink   cfg
);
  import pfa_pkg::*;

  pfa_cmd_t  cmd;
  pfa_stat_t stat;

  pfa_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cmd  (cmd)
  );

  pfa_dp #(
    .NUM_RANGES  (NUM_RANGES),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .rsp  (rsp),
    .cfg  (cfg),
    .cmd  (cmd),
    .stat (stat)
  );

endmodule

/* rtl/core/pfa_checker.sv */
// port-level assertion checker for the page frame allocator, bound to the top level
`include "assert_macros.svh"

module pfa_checker (
  input logic       clk,
  input logic       rst,
  pfa_req_if.sink   req,
  pfa_rsp_if.source rsp
);
  import pfa_pkg::*;

  // a stalled response holds
  `ASSERT_NEXT(a_rsp_hold, clk, rst, rsp.valid && !rsp.ready, rsp.valid && $stable(rsp.frame) && $stable(rsp.status) && $stable(rsp.free_count))

  // one request in flight: ready drops right after an accept
  `ASSERT_NEXT(a_one_in_flight, clk, rst, req.valid && req.ready, !req.ready)

  // a new response only comes out of a busy cycle
  `ASSERT_IMPLIES(a_rsp_from_work, clk, rst, $rose(rsp.valid), $past(!req.ready))

  // failed requests never carry a frame
  `ASSERT_IMPLIES(a_fail_no_frame, clk, rst, rsp.valid && rsp.status != STATUS_OK, rsp.frame == '0)

endmodule

bind page_frame_allocator pfa_checker u_pfa_checker (
  .clk (clk),
  .rst (rst),
  .req (req),
  .rsp (rsp)
);

/* verif/tb_top.sv */
// self-checking testbench for the page frame allocator: scoreboard, drivers and phases
`timescale 1ns / 100ps

module tb_top;
  import pfa_pkg::*;

  localparam int NUM_RANGES  = 16;
  localparam int STACK_DEPTH = 1024;
  localparam int IDLE_GAP    = 40;
  localparam int HOLD_CYCLES = 300;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct {
    logic [OP_W-1:0]  op;
    logic [IDX_W-1:0] idx;
    frame_t           start;
    frame_t           frames;
    frame_t           addr;
  } alloc_req_t;

  typedef struct {
    frame_t              frame;
    logic [STATUS_W-1:0] status;
    frame_t              count;
  } alloc_rsp_t;

  typedef enum int {MIX_TRAFFIC, FREE_ONLY, ALLOC_ONLY} stream_kind_t;

  class frame_alloc_scoreboard;
    frame_t               range_base[NUM_RANGES];
    frame_t               range_len[NUM_RANGES];
    logic [IDX_W-1:0]     cached_idx;
    frame_t               free_total;
    frame_t               recycled[$];
    logic [RCOUNT_W-1:0]  range_limit;
    frame_t               boot_lo;
    frame_t               boot_hi;
    logic                 sys_ready;
    alloc_rsp_t           expected_rsp[$];
    int                   errors;

    function new();
      foreach (range_base[i]) begin
        range_base[i] = '0;
        range_len[i]  = '0;
      end
      cached_idx  = '0;
      free_total  = '0;
      range_limit = '0;
      boot_lo     = '0;
      boot_hi     = '1;
      sys_ready   = 1'b0;
      errors      = 0;
    endfunction

    task report(input string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      errors++;
    endtask

    function void set_register(input logic [CFG_IDX_W-1:0] idx, input frame_t val);
      case (idx)
        REG_RANGE_COUNT: range_limit = val[RCOUNT_W-1:0];
        REG_BOOT_START:  boot_lo = val;
        REG_BOOT_END:    boot_hi = val;
        REG_ARCH_READY:  sys_ready = val[0];
        default: ;
      endcase
    endfunction

    function bit range_fits(input int i);
      if (range_len[i] == '0) return 0;
      if (sys_ready) return 1;
      // window end is exclusive and the first frame needs one past it
      return (range_base[i] >= boot_lo) &&
             (({1'b0, range_base[i]} + 37'd1) < {1'b0, boot_hi});
    endfunction

    function void note_request(input alloc_req_t it);
      alloc_rsp_t r;
      logic [36:0] sum;
      frame_t old_len;
      int sel;
      int limit;
      bit found;
      r.frame  = '0;
      r.status = STATUS_OK;
      case (it.op)
        OP_LOAD: begin
          old_len = range_len[it.idx];
          free_total = (free_total > old_len) ? free_total - old_len : '0;
          sum = {1'b0, free_total} + {1'b0, it.frames};
          free_total = sum[36] ? '1 : sum[35:0];
          range_base[it.idx] = it.start;
          range_len[it.idx]  = it.frames;
        end
        OP_ALLOC: begin
          found = 0;
          if (recycled.size() > 0) begin
            r.frame = recycled.pop_back();
            found = 1;
          end else begin
            sel = int'(cached_idx);
            found = range_fits(sel);
            limit = (int'(range_limit) > NUM_RANGES) ? NUM_RANGES : int'(range_limit);
            for (int i = 0; i < limit && !found; i++) begin
              if (range_fits(i)) begin
                sel = i;
                found = 1;
              end
            end
            if (found) begin
              cached_idx = IDX_W'(sel);
              r.frame = range_base[sel];
              range_base[sel] = range_base[sel] + 1'b1;
              range_len[sel]  = range_len[sel] - 1'b1;
            end
          end
          if (found) begin
            if (free_total != '0) free_total = free_total - 1'b1;
          end else begin
            r.status = STATUS_NOFIT;
            r.frame  = '0;
          end
        end
        OP_FREE: begin
          if (recycled.size() >= STACK_DEPTH) begin
            r.status = STATUS_FULL;
          end else begin
            recycled.push_back(it.addr);
            if (free_total != '1) free_total = free_total + 1'b1;
          end
        end
        default: ;
      endcase
      r.count = free_total;
      expected_rsp.push_back(r);
    endfunction

    task check_response(input alloc_rsp_t got);
      alloc_rsp_t want;
      if (expected_rsp.size() == 0) begin
        report("response with no request pending");
      end else begin
        want = expected_rsp.pop_front();
        if (got.frame !== want.frame)
          report($sformatf("frame got %h want %h", got.frame, want.frame));
        if (got.status !== want.status)
          report($sformatf("status got %0d want %0d", got.status, want.status));
        if (got.count !== want.count)
          report($sformatf("free_count got %h want %h", got.count, want.count));
      end
    endtask
  endclass

  logic clk;
  logic rst;
  logic hold_off_req;
  frame_alloc_scoreboard sb;

  pfa_req_if req_ch ();
  pfa_rsp_if rsp_ch ();
  pfa_cfg_if cfg_ch ();

  page_frame_allocator u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  initial begin
    #20_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // accepted requests, responses and register writes
  always @(posedge clk) begin
    alloc_req_t it;
    alloc_rsp_t got;
    if (!rst) begin
      if (req_ch.valid && req_ch.ready) begin
        it.op     = req_ch.op;
        it.idx    = req_ch.range_index;
        it.start  = req_ch.range_start;
        it.frames = req_ch.range_frames;
        it.addr   = req_ch.frame_addr;
        sb.note_request(it);
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        got.frame  = rsp_ch.frame;
        got.status = rsp_ch.status;
        got.count  = rsp_ch.free_count;
        sb.check_response(got);
      end
      if (cfg_ch.valid && cfg_ch.ready)
        sb.set_register(cfg_ch.index, cfg_ch.data);
    end
  end

  // response side stalls on changing patterns, with one long hold-off on request
  initial begin
    int mode;
    int span;
    int tick;
    rsp_ch.ready = 1'b0;
    tick = 0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(16, 96);
      repeat (span) begin
        @(negedge clk);
        tick++;
        if (hold_off_req) begin
          rsp_ch.ready <= 1'b0;
          repeat (HOLD_CYCLES) @(negedge clk);
          hold_off_req = 1'b0;
        end
        case (mode)
          0: rsp_ch.ready <= 1'b1;
          1: rsp_ch.ready <= 1'($urandom_range(0, 1));
          2: rsp_ch.ready <= (tick % 4 == 0);
          default: rsp_ch.ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  function automatic frame_t rand_frame();
    frame_t f;
    f[35:32] = 4'($urandom);
    f[31:0]  = $urandom;
    return f;
  endfunction

  function automatic alloc_req_t make_req(input logic [OP_W-1:0] op,
                                          input logic [IDX_W-1:0] idx,
                                          input frame_t start, input frame_t frames,
                                          input frame_t addr);
    alloc_req_t it;
    it.op     = op;
    it.idx    = idx;
    it.start  = start;
    it.frames = frames;
    it.addr   = addr;
    return it;
  endfunction

  function automatic alloc_req_t rand_request(input stream_kind_t kind);
    alloc_req_t it;
    int pick;
    it = make_req(OP_ALLOC, IDX_W'($urandom), rand_frame(), rand_frame(), rand_frame());
    pick = $urandom_range(0, 99);
    if (kind == FREE_ONLY) begin
      it.op = OP_FREE;
    end else if (kind == ALLOC_ONLY) begin
      it.op = OP_ALLOC;
    end else if (pick < 30) begin
      it.op = OP_LOAD;
      // most ranges low enough to meet a boot window
      if ($urandom_range(0, 3) != 0) it.start = frame_t'($urandom_range(0, 1023));
      case ($urandom_range(0, 9))
        0: ;
        1: it.frames = '1;
        2: it.frames = '0;
        default: it.frames = frame_t'($urandom_range(1, 8));
      endcase
    end else if (pick < 70) begin
      it.op = OP_ALLOC;
    end else if (pick < 95) begin
      it.op = OP_FREE;
    end else begin
      it.op = OP_UNUSED;
    end
    return it;
  endfunction

  task automatic send_request(input alloc_req_t it);
    @(negedge clk);
    req_ch.valid        <= 1'b1;
    req_ch.op           <= it.op;
    req_ch.range_index  <= it.idx;
    req_ch.range_start  <= it.start;
    req_ch.range_frames <= it.frames;
    req_ch.frame_addr   <= it.addr;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  task automatic write_config(input logic [CFG_IDX_W-1:0] idx, input frame_t val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (sb.expected_rsp.size() != 0) @(posedge clk);
    repeat (IDLE_GAP) @(posedge clk);
  endtask

  task automatic run_stream(input int count, input stream_kind_t kind);
    int sent;
    int burst;
    int gap;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 12);
      for (int k = 0; k < burst && sent < count; k++) begin
        send_request(rand_request(kind));
        sent++;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk);
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    wait_idle();
  endtask

  initial begin
    frame_t lo;
    sb = new();
    hold_off_req = 1'b0;
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.op = OP_LOAD;
    req_ch.range_index = '0;
    req_ch.range_start = '0;
    req_ch.range_frames = '0;
    req_ch.frame_addr = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_RANGE_COUNT;
    cfg_ch.data = '0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    repeat (IDLE_GAP) @(posedge clk);

    // reset settings: empty table, no search, full boot window
    send_request(make_req(OP_ALLOC, 4'd0, '0, '0, '0));
    send_request(make_req(OP_UNUSED, IDX_W'($urandom), rand_frame(), rand_frame(),
                          rand_frame()));
    send_request(make_req(OP_LOAD, 4'd0, 36'h100, 36'd3, '0));
    // cached entry is used although range_count is zero
    send_request(make_req(OP_ALLOC, 4'd0, '0, '0, '0));
    send_request(make_req(OP_FREE, 4'd0, '0, '0, '1));
    send_request(make_req(OP_FREE, 4'd0, '0, '0, '0));
    send_request(make_req(OP_ALLOC, 4'd0, '0, '0, '0));
    send_request(make_req(OP_ALLOC, 4'd0, '0, '0, '0));
    // count saturates high, then a free at the top leaves it there
    send_request(make_req(OP_LOAD, 4'd15, '1, '1, '0));
    send_request(make_req(OP_LOAD, 4'd14, 36'h200, '1, '0));
    send_request(make_req(OP_FREE, 4'd0, '0, '0, 36'h5));
    send_request(make_req(OP_ALLOC, 4'd0, '0, '0, '0));
    // subtract saturates at zero while entry 14 still holds frames
    send_request(make_req(OP_LOAD, 4'd15, 36'h300, '0, '0));
    send_request(make_req(OP_LOAD, 4'd0, 36'h100, '0, '0));
    send_request(make_req(OP_ALLOC, 4'd0, '0, '0, '0));
    wait_idle();

    // oversized range_count, boot window two frames wide
    write_config(REG_RANGE_COUNT, 36'd31);
    write_config(REG_BOOT_START, 36'h200);
    write_config(REG_BOOT_END, 36'h202);
    send_request(make_req(OP_ALLOC, 4'd0, '0, '0, '0));
    send_request(make_req(OP_ALLOC, 4'd0, '0, '0, '0));
    wait_idle();
    write_config(REG_ARCH_READY, 36'd1);
    send_request(make_req(OP_ALLOC, 4'd0, '0, '0, '0));
    wait_idle();

    // first frame wraps past the top frame number
    write_config(REG_RANGE_COUNT, 36'd16);
    send_request(make_req(OP_LOAD, 4'd14, '0, '0, '0));
    send_request(make_req(OP_LOAD, 4'd15, '1, 36'd2, '0));
    send_request(make_req(OP_ALLOC, 4'd0, '0, '0, '0));
    send_request(make_req(OP_ALLOC, 4'd0, '0, '0, '0));
    wait_idle();

    // random traffic, boot stage over, with the long response hold-off
    write_config(REG_RANGE_COUNT, frame_t'($urandom_range(1, 16)));
    write_config(REG_BOOT_END, '1);
    hold_off_req = 1'b1;
    run_stream(110, MIX_TRAFFIC);

    // boot stage with a random window over the low frames
    lo = frame_t'($urandom_range(0, 256));
    write_config(REG_ARCH_READY, 36'd0);
    write_config(REG_RANGE_COUNT, 36'd16);
    write_config(REG_BOOT_START, lo);
    write_config(REG_BOOT_END, lo + frame_t'($urandom_range(0, 768)));
    run_stream(110, MIX_TRAFFIC);

    // empty window: only recycled frames can be handed out
    write_config(REG_RANGE_COUNT, 36'd31);
    write_config(REG_BOOT_START, '1);
    write_config(REG_BOOT_END, '0);
    run_stream(50, MIX_TRAFFIC);
    write_config(REG_BOOT_END, '1);
    run_stream(50, MIX_TRAFFIC);

    // no search, cached entry only
    write_config(REG_ARCH_READY, 36'd1);
    write_config(REG_RANGE_COUNT, 36'd0);
    write_config(REG_BOOT_START, '0);
    run_stream(110, MIX_TRAFFIC);

    // a run of frees onto the recycle stack, then take some back
    write_config(REG_RANGE_COUNT, 36'd16);
    run_stream(40, FREE_ONLY);
    run_stream(12, ALLOC_ONLY);

    if (sb.expected_rsp.size() != 0)
      sb.report($sformatf("%0d responses never arrived", sb.expected_rsp.size()));
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
